>>> rtl/eul_pkg.sv
// Shared types and constants of the Euler model matrix unit.
`default_nettype none
package eul_pkg;

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned ANGLE_W     = 14;
  localparam int unsigned COL_W       = 2;
  localparam int unsigned IN_TDATA_W  = 240;
  localparam int unsigned OUT_TDATA_W = 136;

  localparam logic [COL_W-1:0]   COL_FIRST = 2'd0;
  localparam logic [COL_W-1:0]   COL_LAST  = 2'd3;
  localparam logic [FIELD_W-1:0] ONE_Q16   = 32'h0001_0000;

  typedef struct packed {
    logic st_b;
    logic st_c;
    logic st_d;
    logic st_e;
  } trig_en_t;

endpackage
`default_nettype wire

>>> rtl/eul_sincos.sv
// Four-stage angle wrap, quadrant fold and quarter-wave sine/cosine lookup.
`default_nettype none
module eul_sincos
  import eul_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 4,
  parameter int unsigned TRIG_FRAC_BITS  = 14
) (
  input  wire                              clk_i,
  input  wire  trig_en_t                   en_i,
  input  wire  logic [ANGLE_W-1:0]         angle_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);

  localparam int unsigned TF      = TRIG_FRAC_BITS;
  localparam int unsigned QUARTER = 90 << ANGLE_FRAC_BITS;
  localparam int unsigned FULL    = 4 * QUARTER;
  localparam int unsigned SPAN    = 1 << (ANGLE_W - 1);
  localparam int unsigned OFFSET  = ((SPAN + FULL - 1) / FULL) * FULL;
  localparam int unsigned UMAX    = OFFSET + SPAN - 1;
  localparam int unsigned UW      = $clog2(UMAX + 1);
  localparam int unsigned QMAX    = UMAX / FULL;
  localparam int unsigned QW      = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  localparam int unsigned AW      = $clog2(FULL);
  localparam int unsigned IW      = $clog2(QUARTER + 1);
  localparam logic [63:0] RECIP   = (64'd1 << 32) / FULL;
  localparam logic [63:0] PI_Q32  = 64'h3_243F_6A89;
  localparam logic [63:0] ANG_DEN = 64'd720 << ANGLE_FRAC_BITS;
  localparam logic [63:0] ONE_T   = 64'd1 << TF;

  function automatic logic [TF:0] quarter_sin(input int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    x    = (64'(r) * PI_Q32) / ANG_DEN;
    x2   = (x * x) >> 30;
    sum  = x;
    term = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    v = (sum + (64'd1 << (29 - TF))) >> (30 - TF);
    if (v > ONE_T) begin
      v = ONE_T;
    end
    return v[TF:0];
  endfunction

  logic [TF:0] sin_tab [QUARTER+1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
    assign sin_tab[g] = quarter_sin(g);
  end

  logic [UW-1:0]    u_d;
  logic [UW+31:0]   qprod;
  logic [UW-1:0]    u_q;
  logic [QW-1:0]    q_q;
  logic [UW-1:0]    rem;
  logic [AW-1:0]    a_d, a_q;
  logic [1:0]       quad;
  logic [IW-1:0]    r_idx;
  logic [IW-1:0]    sidx_d, cidx_d, sidx_q, cidx_q;
  logic             sneg_d, cneg_d, sneg_q, cneg_q;
  logic signed [TF+1:0] s_d, c_d;

  always_comb begin
    u_d   = UW'($signed(angle_i)) + UW'(OFFSET);
    qprod = (UW+32)'(u_d) * (UW+32)'(RECIP);
  end

  always_comb begin
    rem = u_q - UW'(UW'(q_q) * UW'(FULL));
    if (rem >= UW'(FULL)) begin
      rem = rem - UW'(FULL);
    end
    a_d = rem[AW-1:0];
  end

  always_comb begin
    if (a_q >= AW'(3 * QUARTER)) begin
      quad  = 2'd3;
      r_idx = IW'(a_q - AW'(3 * QUARTER));
    end else if (a_q >= AW'(2 * QUARTER)) begin
      quad  = 2'd2;
      r_idx = IW'(a_q - AW'(2 * QUARTER));
    end else if (a_q >= AW'(QUARTER)) begin
      quad  = 2'd1;
      r_idx = IW'(a_q - AW'(QUARTER));
    end else begin
      quad  = 2'd0;
      r_idx = IW'(a_q);
    end
    case (quad)
      2'd0: begin
        sidx_d = r_idx;                 sneg_d = 1'b0;
        cidx_d = IW'(QUARTER) - r_idx;  cneg_d = 1'b0;
      end
      2'd1: begin
        sidx_d = IW'(QUARTER) - r_idx;  sneg_d = 1'b0;
        cidx_d = r_idx;                 cneg_d = 1'b1;
      end
      2'd2: begin
        sidx_d = r_idx;                 sneg_d = 1'b1;
        cidx_d = IW'(QUARTER) - r_idx;  cneg_d = 1'b1;
      end
      default: begin
        sidx_d = IW'(QUARTER) - r_idx;  sneg_d = 1'b1;
        cidx_d = r_idx;                 cneg_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    s_d = $signed({1'b0, sin_tab[sidx_q]});
    c_d = $signed({1'b0, sin_tab[cidx_q]});
    if (sneg_q) begin
      s_d = -s_d;
    end
    if (cneg_q) begin
      c_d = -c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.st_b) begin
      u_q <= u_d;
      q_q <= qprod[32+QW-1:32];
    end
    if (en_i.st_c) begin
      a_q <= a_d;
    end
    if (en_i.st_d) begin
      sidx_q <= sidx_d;
      cidx_q <= cidx_d;
      sneg_q <= sneg_d;
      cneg_q <= cneg_d;
    end
    if (en_i.st_e) begin
      sin_o <= s_d;
      cos_o <= c_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/euler_trs_model_matrix_unit.sv
// Top level: model matrix T*Rz*Ry*Rx*S from one transform, emitted column by column.
// The four-column output serializer takes a new item only once its last column is taken;
// the ten-stage arithmetic pipeline takes an item in every cycle unless back-pressure stalls it.
// Reset clears all valid bits and the column counter; payload registers are not reset.
`default_nettype none
module euler_trs_model_matrix_unit
  import eul_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = 4,
  parameter int unsigned TRIG_FRAC_BITS  = 14
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // pos_x, pos_y, pos_z, scale_x, scale_y, scale_z, angle_x, angle_y, angle_z
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  wire                    m_axis_tready_i,
  // column_index, entry_row0, entry_row1, entry_row2, entry_row3
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o
);

  localparam int unsigned TF    = TRIG_FRAC_BITS;
  localparam int unsigned TW    = TF + 2;
  localparam int unsigned ZW    = 2 * TF + 3;
  localparam int unsigned RW    = 3 * TF + 3;
  localparam int unsigned PB    = 3 * TF;
  localparam int unsigned SH_R  = (PB > 30) ? PB - 30 : 0;
  localparam int unsigned SH_L  = (PB < 30) ? 30 - PB : 0;
  localparam int unsigned XW    = RW + SH_L + 1;
  localparam logic [63:0] HALF  = (SH_R > 0) ? (64'd1 << ((SH_R > 0) ? SH_R - 1 : 0)) : 64'd0;
  localparam int unsigned R30W  = 33;
  localparam int unsigned PW    = R30W + FIELD_W;
  localparam int unsigned NST   = 10;
  localparam int unsigned ST_ZY = 5;
  localparam int unsigned ST_R  = 6;
  localparam int unsigned ST_30 = 7;
  localparam int unsigned ST_P  = 8;
  localparam int unsigned ST_E  = 9;

  logic [NST-1:0] v_q;
  logic [NST:0]   rdy;
  logic [NST-1:0] en;

  logic [FIELD_W-1:0] pos_q [NST][3];
  logic [FIELD_W-1:0] scl_q [ST_P][3];
  logic [ANGLE_W-1:0] ang_q [3];

  logic signed [TW-1:0]   sn [3];
  logic signed [TW-1:0]   cs [3];
  logic signed [TW-1:0]   sx_q, cx_q;
  logic signed [ZW-1:0]   zy_d [3][3];
  logic signed [ZW-1:0]   zy_q [3][3];
  logic signed [RW-1:0]   r_d  [3][3];
  logic signed [RW-1:0]   r_q  [3][3];
  logic signed [R30W-1:0] r30_d [3][3];
  logic signed [R30W-1:0] r30_q [3][3];
  logic signed [PW-1:0]   p_d  [3][3];
  logic signed [PW-1:0]   p_q  [3][3];
  logic [FIELD_W-1:0]     e_d  [3][3];
  logic [FIELD_W-1:0]     e_q  [3][3];

  logic [FIELD_W-1:0] ser_ent_q [3][3];
  logic [FIELD_W-1:0] ser_pos_q [3];
  logic               ser_v_q, ser_v_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic               ser_free, ser_load, out_take;

  trig_en_t trig_en;

  assign out_take = ser_v_q && m_axis_tready_i;
  assign ser_free = !ser_v_q || (out_take && (col_q == COL_LAST));
  assign ser_load = ser_free && v_q[ST_E];

  always_comb begin
    rdy[NST] = ser_free;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign en              = rdy[NST-1:0];
  assign s_axis_tready_o = rdy[0];
  assign trig_en         = '{st_b: en[1], st_c: en[2], st_d: en[3], st_e: en[4]};

  for (genvar a = 0; a < 3; a++) begin : g_trig
    eul_sincos #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_sincos (
      .clk_i  (clk_i),
      .en_i   (trig_en),
      .angle_i(ang_q[a]),
      .sin_o  (sn[a]),
      .cos_o  (cs[a])
    );
  end

  always_comb begin
    zy_d[0][0] = ZW'(cs[2]) * ZW'(cs[1]);
    zy_d[0][1] = -(ZW'(sn[2]) <<< TF);
    zy_d[0][2] = -(ZW'(cs[2]) * ZW'(sn[1]));
    zy_d[1][0] = ZW'(sn[2]) * ZW'(cs[1]);
    zy_d[1][1] = ZW'(cs[2]) <<< TF;
    zy_d[1][2] = -(ZW'(sn[2]) * ZW'(sn[1]));
    zy_d[2][0] = ZW'(sn[1]) <<< TF;
    zy_d[2][1] = '0;
    zy_d[2][2] = ZW'(cs[1]) <<< TF;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_d[i][0] = RW'(zy_q[i][0]) <<< TF;
      r_d[i][1] = RW'(zy_q[i][1]) * RW'(cx_q) - RW'(zy_q[i][2]) * RW'(sx_q);
      r_d[i][2] = RW'(zy_q[i][1]) * RW'(sx_q) + RW'(zy_q[i][2]) * RW'(cx_q);
    end
  end

  always_comb begin
    logic signed [XW-1:0] t;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        t = (XW'(r_q[i][j]) + $signed(XW'(HALF))) >>> SH_R;
        t = t <<< SH_L;
        r30_d[i][j] = t[R30W-1:0];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_d[i][j] = PW'(r30_q[i][j]) * PW'($signed(scl_q[ST_P-1][j]));
      end
    end
  end

  always_comb begin
    logic signed [PW-1:0] rnd;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rnd = (p_q[i][j] + $signed(PW'(64'd1 << 29))) >>> 30;
        if (rnd > $signed(PW'(32'h7FFF_FFFF))) begin
          e_d[i][j] = 32'h7FFF_FFFF;
        end else if (rnd < -$signed(PW'(64'h8000_0000))) begin
          e_d[i][j] = 32'h8000_0000;
        end else begin
          e_d[i][j] = rnd[FIELD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= (k == 0) ? s_axis_tvalid_i : v_q[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[0][i] <= s_axis_tdata_i[FIELD_W*i +: FIELD_W];
        scl_q[0][i] <= s_axis_tdata_i[FIELD_W*(3+i) +: FIELD_W];
        ang_q[i]    <= s_axis_tdata_i[6*FIELD_W + ANGLE_W*i +: ANGLE_W];
      end
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        pos_q[k] <= pos_q[k-1];
      end
    end
    for (int k = 1; k < ST_P; k++) begin
      if (en[k]) begin
        scl_q[k] <= scl_q[k-1];
      end
    end
    if (en[ST_ZY]) begin
      zy_q <= zy_d;
      sx_q <= sn[0];
      cx_q <= cs[0];
    end
    if (en[ST_R]) begin
      r_q <= r_d;
    end
    if (en[ST_30]) begin
      r30_q <= r30_d;
    end
    if (en[ST_P]) begin
      p_q <= p_d;
    end
    if (en[ST_E]) begin
      e_q <= e_d;
    end
    if (ser_load) begin
      ser_ent_q <= e_q;
      ser_pos_q <= pos_q[ST_E];
    end
  end

  always_comb begin
    ser_v_d = ser_v_q;
    col_d   = col_q;
    if (ser_load) begin
      ser_v_d = 1'b1;
      col_d   = COL_FIRST;
    end else if (out_take) begin
      if (col_q == COL_LAST) begin
        ser_v_d = 1'b0;
      end
      col_d = col_q + COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      col_q   <= COL_FIRST;
    end else begin
      ser_v_q <= ser_v_d;
      col_q   <= col_d;
    end
  end

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[COL_W-1:0] = col_q;
    if (col_q == COL_LAST) begin
      for (int i = 0; i < 3; i++) begin
        m_axis_tdata_o[COL_W + FIELD_W*i +: FIELD_W] = ser_pos_q[i];
      end
      m_axis_tdata_o[COL_W + FIELD_W*3 +: FIELD_W] = ONE_Q16;
    end else begin
      for (int i = 0; i < 3; i++) begin
        m_axis_tdata_o[COL_W + FIELD_W*i +: FIELD_W] = ser_ent_q[i][col_q];
      end
      m_axis_tdata_o[COL_W + FIELD_W*3 +: FIELD_W] = '0;
    end
  end

  assign m_axis_tvalid_o = ser_v_q;
  assign m_axis_tlast_o  = (col_q == COL_LAST);

endmodule
`default_nettype wire

>>> rtl/eul_checker.sv
// Port-level checks of the model matrix unit, bound to the top level.
`default_nettype none
module eul_checker
  import eul_pkg::*;
(
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   s_axis_tvalid_i,
  input wire                   s_axis_tready_o,
  input wire [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input wire                   m_axis_tvalid_o,
  input wire                   m_axis_tready_i,
  input wire [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire                   m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  a_last_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[COL_W-1:0] == COL_LAST)))
    else $error("tlast does not match the last column");

  a_col_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (m_axis_tdata_o[COL_W-1:0] ==
                          $past(m_axis_tdata_o[COL_W-1:0]) + COL_W'(1)))
    else $error("matrix columns not delivered in sequence");

  a_row3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[COL_W+3*FIELD_W +: FIELD_W] ==
                         (m_axis_tlast_o ? ONE_Q16 : '0)))
    else $error("bottom row entry wrong");

endmodule

bind euler_trs_model_matrix_unit eul_checker u_eul_checker (.*);
`default_nettype wire
